// File: rtl/pmi_pkg.sv
package pmi_pkg;

    localparam int MAX_LEN = 64;
    localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW      = $clog2(MAX_LEN + 1);
    localparam int CW      = AW;
    localparam int INS_W   = 6;
    localparam int INS_MAX = 63;

    typedef struct packed {
        logic          load;
        logic          clr;
        logic          res_clr;
        logic          issue;
        logic [AW-1:0] l;
        logic [AW-1:0] gap;
    } t_cmd;

    typedef struct packed {
        logic [LW-1:0] len;
    } t_stat;

endpackage

// File: rtl/palindrome_min_insertions_top.sv
// Minimum insertions to make a byte string a palindrome. Bytes are transferred
// one per cycle while busy is low; a byte after the first 64 is dropped and
// flags overflow. After the byte marked last, busy rises and the interval DP
// runs one cell per cycle through a two-stage read/compute pipeline, with a
// drain state after each diagonal. The result is shown for exactly one cycle
// with o_done high and cannot be held off; o_insertions and o_overflow are
// valid only in that cycle. busy falls the cycle after.
module palindrome_min_insertions_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [7:0]                i_char_byte,
    input  logic                      i_is_last,
    output logic                      busy,
    output logic                      o_done,
    output logic [pmi_pkg::INS_W-1:0] o_insertions,
    output logic                      o_overflow
);

    pmi_pkg::t_cmd  cmd;
    pmi_pkg::t_stat stat;

    pmi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    pmi_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_char_byte  (i_char_byte),
        .o_stat       (stat),
        .o_insertions (o_insertions),
        .o_overflow   (o_overflow)
    );

endmodule

// File: rtl/pmi_ctrl.sv
module pmi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_is_last,
    input  pmi_pkg::t_stat i_stat,
    output pmi_pkg::t_cmd  o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [pmi_pkg::AW-1:0] r_l, n_l;
    logic [pmi_pkg::AW-1:0] r_gap, n_gap;
    logic [pmi_pkg::LW-1:0] len_m1;

    assign len_m1 = i_stat.len - pmi_pkg::LW'(1);

    always_comb begin
        n_state = r_state;
        n_l     = r_l;
        n_gap   = r_gap;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_is_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_gap = pmi_pkg::AW'(1);
                n_l   = '0;
                if (i_stat.len == pmi_pkg::LW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (pmi_pkg::LW'(r_l) + pmi_pkg::LW'(r_gap) == len_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_l = r_l + pmi_pkg::AW'(1);
                end
            end
            S_DRAIN: begin
                if (pmi_pkg::LW'(r_gap) == len_m1) begin
                    n_state = S_DONE;
                end else begin
                    n_gap   = r_gap + pmi_pkg::AW'(1);
                    n_l     = '0;
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l     <= '0;
            r_gap   <= '0;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_gap   <= n_gap;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_cmd.load    = i_start && (r_state == S_IDLE);
    assign o_cmd.clr     = (r_state == S_DONE);
    assign o_cmd.res_clr = (r_state == S_START);
    assign o_cmd.issue   = (r_state == S_RUN);
    assign o_cmd.l       = r_l;
    assign o_cmd.gap     = r_gap;

endmodule

// File: rtl/pmi_datapath.sv
module pmi_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pmi_pkg::t_cmd             i_cmd,
    input  logic [7:0]                i_char_byte,
    output pmi_pkg::t_stat            o_stat,
    output logic [pmi_pkg::INS_W-1:0] o_insertions,
    output logic                      o_overflow
);

    logic [7:0]             r_chars  [pmi_pkg::MAX_LEN];
    logic [pmi_pkg::CW-1:0] r_diag_a [pmi_pkg::MAX_LEN];
    logic [pmi_pkg::CW-1:0] r_diag_b [pmi_pkg::MAX_LEN];

    logic [pmi_pkg::LW-1:0] r_len;
    logic                   r_ovf;
    logic                   room;

    logic [pmi_pkg::AW-1:0] a_l, a_l1, a_lg;
    logic [7:0]             r_c0, r_c1;
    logic [pmi_pkg::CW-1:0] r_a0, r_a1, r_b0, r_b1;

    logic                   r_s2_vld;
    logic [pmi_pkg::AW-1:0] r_s2_l;
    logic                   r_s2_par, r_s2_g1, r_s2_g2;

    logic [pmi_pkg::CW-1:0] older, newer0, newer1, mn, v;
    logic [pmi_pkg::CW-1:0] r_res;
    logic [pmi_pkg::CW+pmi_pkg::INS_W-1:0] res_wide;

    assign room = (r_len < pmi_pkg::LW'(pmi_pkg::MAX_LEN));
    assign a_l  = i_cmd.l;
    assign a_l1 = i_cmd.l + pmi_pkg::AW'(1);
    assign a_lg = i_cmd.l + i_cmd.gap;

    // byte store: one write port, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_chars[r_len[pmi_pkg::AW-1:0]] <= i_char_byte;
        end
        r_c0 <= r_chars[a_l];
        r_c1 <= r_chars[a_lg];
    end

    // diagonal of gap g lives in buffer g[0], written in place over gap g-2
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && !r_s2_par) begin
            r_diag_a[r_s2_l] <= v;
        end
        r_a0 <= r_diag_a[a_l];
        r_a1 <= r_diag_a[a_l1];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && r_s2_par) begin
            r_diag_b[r_s2_l] <= v;
        end
        r_b0 <= r_diag_b[a_l];
        r_b1 <= r_diag_b[a_l1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_cmd.issue;
        end
        r_s2_l   <= i_cmd.l;
        r_s2_par <= i_cmd.gap[0];
        r_s2_g1  <= (i_cmd.gap == pmi_pkg::AW'(1));
        r_s2_g2  <= (i_cmd.gap == pmi_pkg::AW'(2));
    end

    // gaps below one cost nothing: mask operands instead of clearing
    always_comb begin
        older  = (r_s2_g1 || r_s2_g2) ? '0 : (r_s2_par ? r_b1 : r_a1);
        newer0 = r_s2_g1 ? '0 : (r_s2_par ? r_a0 : r_b0);
        newer1 = r_s2_g1 ? '0 : (r_s2_par ? r_a1 : r_b1);
        mn     = (newer0 < newer1) ? newer0 : newer1;
        v      = (r_c0 == r_c1) ? older : mn + pmi_pkg::CW'(1);
    end

    // last write at l = 0 is the whole string
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clr) begin
            r_res <= '0;
        end else if (r_s2_vld && (r_s2_l == '0)) begin
            r_res <= v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.clr) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.load) begin
            if (room) begin
                r_len <= r_len + pmi_pkg::LW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign res_wide     = (pmi_pkg::CW + pmi_pkg::INS_W)'(r_res);
    assign o_insertions = (res_wide > (pmi_pkg::CW + pmi_pkg::INS_W)'(pmi_pkg::INS_MAX))
                        ? pmi_pkg::INS_W'(pmi_pkg::INS_MAX)
                        : res_wide[pmi_pkg::INS_W-1:0];
    assign o_overflow   = r_ovf;
    assign o_stat.len   = r_len;

endmodule

// File: rtl/pmi_checker.sv
module pmi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic i_is_last,
    input logic busy,
    input logic o_done
);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe longer than one cycle");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_is_last |=> busy)
        else $error("last byte did not start the solve");

    a_mid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_is_last |=> !busy && !o_done)
        else $error("non-final transfer caused activity");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result shown while idle");

    a_fall_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a result");

endmodule

bind palindrome_min_insertions_top pmi_checker u_pmi_checker (.*);
